@@ rtl/bppl_pkg.sv @@
// ----------------------------------------------------------------------------
// bppl_pkg
// Shared types and constants for the bucket priority point lists block.
// ----------------------------------------------------------------------------
package bppl_pkg;

    localparam int NUM_POINTS_DEF   = 1024;
    localparam int NUM_MEASURES_DEF = 256;

    localparam logic OP_ENTER  = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic ST_DONE     = 1'b0;
    localparam logic ST_NOBUCKET = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] measure;
        logic [9:0] point;
    } t_in_item;

    typedef struct packed {
        logic       status;
        logic       all_empty;
        logic [7:0] top_measure;
        logic [9:0] top_first_point;
    } t_out_item;

endpackage

@@ rtl/bucket_priority_point_lists_top.sv @@
// ----------------------------------------------------------------------------
// bucket_priority_point_lists_top
// Bucket priority queue of points with doubly linked per-bucket lists.
// ----------------------------------------------------------------------------
// A remove or an enter into an existing bucket passes the read, decode, top read
// and output states; creating a bucket adds a descending walk over the buckets,
// each walk step being one lower-link memory read, and two link-write states.
// A new request is taken only in the idle state, after the last one is through;
// a result still waiting only holds the sequencer in its output state.
// reset clears the bucket used flags and the chain ends; link memories are not cleared.
module bucket_priority_point_lists_top #(
    parameter int NUM_POINTS   = bppl_pkg::NUM_POINTS_DEF,
    parameter int NUM_MEASURES = bppl_pkg::NUM_MEASURES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  bppl_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output bppl_pkg::t_out_item o_data
);
    import bppl_pkg::*;

    localparam int PW = $clog2(NUM_POINTS);
    localparam int MW = $clog2(NUM_MEASURES);
    localparam int PL = PW + 1;
    localparam int ML = MW + 1;
    localparam logic [PL-1:0] NOP = PL'(NUM_POINTS);
    localparam logic [ML-1:0] NOB = ML'(NUM_MEASURES);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_RD    = 10'b0000000010,
        S_DEC   = 10'b0000000100,
        S_WLK   = 10'b0000001000,
        S_WLKD  = 10'b0000010000,
        S_LINK  = 10'b0000100000,
        S_W2    = 10'b0001000000,
        S_TOP   = 10'b0010000000,
        S_TOPD  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    // memories
    logic [PL-1:0] m_next  [NUM_POINTS];
    logic [PL-1:0] m_prev  [NUM_POINTS];
    logic [PW-1:0] m_first [NUM_MEASURES];
    logic [PW-1:0] m_last  [NUM_MEASURES];
    logic [ML-1:0] m_lower [NUM_MEASURES];
    logic [ML-1:0] m_higher[NUM_MEASURES];
    logic [NUM_MEASURES-1:0] r_used;

    t_state        r_state, n_state;
    logic          r_op;
    logic [MW-1:0] r_m;
    logic [PW-1:0] r_p;
    logic          r_inr;
    logic [ML-1:0] r_top, r_bot, r_walk, r_above;
    logic          r_status;
    logic          r_ovalid;
    t_out_item     r_odata;

    // registered read data
    logic [PL-1:0] r_nx, r_pv;
    logic [PW-1:0] r_first, r_last;
    logic [ML-1:0] r_lo, r_hi, r_wlo;
    logic [PW-1:0] r_tfirst;

    // write ports, one per memory per cycle
    logic          w_next_en, w_prev_en, w_first_en, w_last_en, w_lo_en, w_hi_en;
    logic [PW-1:0] w_next_a, w_prev_a;
    logic [PL-1:0] w_next_d, w_prev_d;
    logic [MW-1:0] w_first_a, w_last_a, w_lo_a, w_hi_a;
    logic [PW-1:0] w_first_d, w_last_d;
    logic [ML-1:0] w_lo_d, w_hi_d;
    logic [MW-1:0] w_lo_ra;
    logic [MW-1:0] w_first_ra;

    logic in_range;
    assign in_range = (ML'(i_data.measure) < NOB) && (PL'(i_data.point) < NOP);
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    // memory writes and registered reads
    always_ff @(posedge i_clk) begin
        if (w_next_en)  m_next[w_next_a]   <= w_next_d;
        if (w_prev_en)  m_prev[w_prev_a]   <= w_prev_d;
        if (w_first_en) m_first[w_first_a] <= w_first_d;
        if (w_last_en)  m_last[w_last_a]   <= w_last_d;
        if (w_lo_en)    m_lower[w_lo_a]    <= w_lo_d;
        if (w_hi_en)    m_higher[w_hi_a]   <= w_hi_d;
        r_nx     <= m_next[r_p];
        r_pv     <= m_prev[r_p];
        r_first  <= m_first[w_first_ra];
        r_last   <= m_last[r_m];
        r_lo     <= m_lower[r_m];
        r_hi     <= m_higher[r_m];
        r_wlo    <= m_lower[w_lo_ra];
        r_tfirst <= m_first[w_first_ra];
    end

    assign w_lo_ra    = r_walk[MW-1:0];
    assign w_first_ra = (r_state == S_TOP || r_state == S_TOPD || r_state == S_OUT) ?
                        r_top[MW-1:0] : r_m;

    logic used_m;
    assign used_m = r_used[r_m];

    // sequencer
    always_comb begin
        n_state = r_state;
        w_next_en = 1'b0; w_prev_en = 1'b0; w_first_en = 1'b0;
        w_last_en = 1'b0; w_lo_en = 1'b0; w_hi_en = 1'b0;
        w_next_a = r_p; w_prev_a = r_p; w_next_d = NOP; w_prev_d = NOP;
        w_first_a = r_m; w_last_a = r_m; w_first_d = r_p; w_last_d = r_p;
        w_lo_a = r_m; w_hi_a = r_m; w_lo_d = NOB; w_hi_d = NOB;
        unique case (r_state)
            S_IDLE: if (i_valid && o_ready) n_state = S_RD;
            S_RD:   n_state = S_DEC;
            S_DEC: begin
                n_state = S_TOP;
                if (r_inr) begin
                    if (r_op == OP_ENTER) begin
                        if (used_m) begin
                            // append at tail
                            w_next_en = (PL'(r_last) < NOP);
                            w_next_a  = r_last;
                            w_next_d  = PL'(r_p);
                            w_prev_en = 1'b1;
                            w_prev_d  = PL'(r_last);
                            w_last_en = 1'b1;
                        end else begin
                            w_first_en = 1'b1;
                            w_last_en  = 1'b1;
                            w_next_en  = 1'b1;
                            n_state    = S_WLK;
                        end
                    end else if (used_m) begin
                        if (r_first == r_p && r_last == r_p) begin
                            // free bucket
                            w_lo_en = (r_hi < NOB);
                            w_lo_a  = r_hi[MW-1:0];
                            w_lo_d  = r_lo;
                            w_hi_en = (r_lo < NOB);
                            w_hi_a  = r_lo[MW-1:0];
                            w_hi_d  = r_hi;
                        end else if (r_first == r_p) begin
                            w_first_en = 1'b1;
                            w_first_d  = r_nx[PW-1:0];
                            w_prev_en  = (r_nx < NOP);
                            w_prev_a   = r_nx[PW-1:0];
                        end else if (r_last == r_p) begin
                            w_last_en = 1'b1;
                            w_last_d  = r_pv[PW-1:0];
                            w_next_en = (r_pv < NOP);
                            w_next_a  = r_pv[PW-1:0];
                        end else begin
                            w_next_en = (r_pv < NOP);
                            w_next_a  = r_pv[PW-1:0];
                            w_next_d  = r_nx;
                            w_prev_en = (r_nx < NOP);
                            w_prev_a  = r_nx[PW-1:0];
                            w_prev_d  = r_pv;
                        end
                    end
                end
            end
            S_WLK: begin
                w_prev_en = 1'b1;
                if (r_walk < NOB && r_walk[MW-1:0] > r_m) n_state = S_WLKD;
                else n_state = S_LINK;
            end
            S_WLKD: n_state = S_WLK;
            S_LINK: begin
                w_hi_en = 1'b1; w_hi_d = r_above;
                w_lo_en = 1'b1; w_lo_d = r_walk;
                n_state = S_W2;
            end
            S_W2: begin
                w_lo_en = (r_above < NOB); w_lo_a = r_above[MW-1:0];
                w_lo_d  = ML'(r_m);
                w_hi_en = (r_walk < NOB); w_hi_a = r_walk[MW-1:0];
                w_hi_d  = ML'(r_m);
                n_state = S_TOP;
            end
            S_TOP:  n_state = S_TOPD;
            S_TOPD: n_state = S_OUT;
            S_OUT:  if (!r_ovalid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_top    <= NOB;
            r_bot    <= NOB;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            // result register loads once the previous result has gone
            if (r_state == S_OUT && (!r_ovalid || i_ready)) r_ovalid <= 1'b1;
            else if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid && o_ready) begin
                    r_op   <= i_data.operation;
                    r_m    <= MW'(i_data.measure);
                    r_p    <= PW'(i_data.point);
                    r_inr  <= in_range;
                    r_status <= ST_DONE;
                end
                S_DEC: begin
                    r_walk  <= r_top;
                    r_above <= NOB;
                    if (r_inr && r_op == OP_REMOVE) begin
                        if (!used_m) r_status <= ST_NOBUCKET;
                        else if (r_first == r_p && r_last == r_p) begin
                            r_used[r_m] <= 1'b0;
                            if (!(r_hi < NOB)) r_top <= r_lo;
                            if (!(r_lo < NOB)) r_bot <= r_hi;
                        end
                    end else if (r_inr && !used_m) begin
                        r_used[r_m] <= 1'b1;
                    end
                end
                S_WLKD: begin
                    r_above <= r_walk;
                    r_walk  <= r_wlo;
                end
                S_W2: begin
                    if (!(r_above < NOB)) r_top <= ML'(r_m);
                    if (!(r_walk < NOB)) r_bot <= ML'(r_m);
                end
                S_OUT: if (!r_ovalid || i_ready) begin
                    r_odata.status <= r_status;
                    if (r_top < NOB) begin
                        r_odata.all_empty       <= 1'b0;
                        r_odata.top_measure     <= 8'(r_top);
                        r_odata.top_first_point <= 10'(r_tfirst);
                    end else begin
                        r_odata.all_empty       <= 1'b1;
                        r_odata.top_measure     <= '0;
                        r_odata.top_first_point <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // checks
    a_noacc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready)
        else $error("ready while busy");
    a_out_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_OUT))
        else $error("result without sequence");
    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_top == NOB) |-> (r_bot == NOB))
        else $error("chain ends disagree");
endmodule
